@@ design/schedule_rendezvous_latency_assert.svh @@
// Assertion macros for the schedule rendezvous latency block.
// Included by the top level; compiles to nothing when SYNTHESIS is set.
`ifndef SCHEDULE_RENDEZVOUS_LATENCY_ASSERT_SVH
`define SCHEDULE_RENDEZVOUS_LATENCY_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define SRL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srl assertion failed");
// Next-cycle implication.
`define SRL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srl assertion failed");
`else
`define SRL_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SRL_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ design/srl_pkg.sv @@
// Shared types and constants for the schedule rendezvous latency block.
// No dependencies; the RTL modules refer to it by scoped names, the bench imports it.
package srl_pkg;

    localparam int MASK_W    = 64;
    localparam int PER_W     = 7;
    localparam int CP_W      = 13;
    localparam int SLOT_W    = 12;
    localparam int ATT_W     = 16;
    localparam int LAT_W     = 28;
    localparam int CFG_IDX_W = 3;
    // a schedule period fits in PER_W bits, so overhang past the common period does too
    localparam int WRAP_BITS = 1 << PER_W;
    localparam int DIV_DW    = 16;
    localparam int DIV_VW    = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_MASK   = 3'd0,
        REG_A_PERIOD = 3'd1,
        REG_B_MASK   = 3'd2,
        REG_B_PERIOD = 3'd3,
        REG_COMMON   = 3'd4
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD_START,
        S_MOD_OFF,
        S_SWEEP,
        S_SCAN,
        S_DIV_ATT,
        S_MUL,
        S_SEEK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [MASK_W-1:0] mask_a;
        logic [PER_W-1:0]  per_a;
        logic [PER_W-1:0]  lim_a;
        logic [MASK_W-1:0] mask_b;
        logic [PER_W-1:0]  per_b;
        logic [PER_W-1:0]  lim_b;
        logic [CP_W-1:0]   n;
    } t_cfg;

    typedef struct packed {
        logic [SLOT_W-1:0] start_slot;
        logic [SLOT_W-1:0] phase_offset;
        logic [ATT_W-1:0]  attempts;
    } t_in;

    typedef struct packed {
        logic [LAT_W-1:0] latency;
        logic             no_overlap;
    } t_out;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quot;
        logic [DIV_VW-1:0] rem;
    } t_div_res;

endpackage

@@ design/schedule_rendezvous_latency.sv @@
// Top level of the schedule rendezvous latency block: sequencer, slot maps, output register.
// Depends on srl_pkg, srl_cfg, srl_div and schedule_rendezvous_latency_assert.svh.
`include "schedule_rendezvous_latency_assert.svh"

// Rendezvous latency between two periodic wake-up schedules. Each input word
// (start slot, phase offset, attempt ordinal) yields one result word: the slot
// distance from the start to the chosen coincidence of schedule A with schedule
// B rotated right by the offset, over the common period n, or a no_overlap flag
// with zero latency when the schedules never meet. One word is in flight at a
// time; the input side is ready only while the sequencer is idle, and a
// finished result waits in its own output register, so the next word can be
// taken before the previous result is collected. Three passes walk the
// one-bit slot maps one slot per cycle (build map B while folding the
// overhang of schedule A into a 128-bit wrap vector, scan for coincidences
// into the coincidence map, then seek from the start slot), and one shared
// bit-serial divider computes start mod n, offset mod n and (attempts-1)
// divided by the coincidence count. The maps are rewritten in full for
// every word, so no clearing pass follows reset. Configuration writes
// are always taken and must only arrive while the block is idle.
module schedule_rendezvous_latency #(
    parameter int PERIOD_MAX = 4096,
    parameter int MASK_BITS  = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  srl_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output srl_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srl_pkg::MASK_W-1:0]      i_cfg_data
);
    localparam int CP_MAX = (1 << srl_pkg::CP_W) - 1;
    localparam int N_MAX  = (PERIOD_MAX < CP_MAX) ? PERIOD_MAX : CP_MAX;
    localparam int AW     = $clog2(N_MAX);
    localparam int NW     = $clog2(N_MAX + 1);
    localparam int PW     = $clog2(N_MAX + srl_pkg::WRAP_BITS + 1);
    localparam int WIX    = $clog2(srl_pkg::WRAP_BITS);
    localparam int MIX    = $clog2(srl_pkg::MASK_W);

    // slot s of a period is awake when it is below the used mask bits and set
    function automatic logic slot_on(input logic [srl_pkg::MASK_W-1:0] mask,
                                     input logic [srl_pkg::PER_W-1:0]  res,
                                     input logic [srl_pkg::PER_W-1:0]  lim);
        return (res < lim) && mask[MIX'(res)];
    endfunction

    srl_pkg::t_cfg      w_cfg;
    srl_pkg::t_div_res  w_div;
    srl_pkg::t_state    r_state;
    srl_pkg::t_state    n_state;

    logic [NW-1:0]                   w_n;
    logic                            w_div_go;
    logic [srl_pkg::DIV_DW-1:0]      w_div_dvd;
    logic [srl_pkg::DIV_VW-1:0]      w_div_dvs;
    logic                            w_load_out;

    // per-word operands
    logic [srl_pkg::SLOT_W-1:0]      r_off;
    logic [srl_pkg::ATT_W-1:0]       r_att;
    logic [AW-1:0]                   r_startm;
    logic [AW-1:0]                   r_offm;
    logic [srl_pkg::ATT_W-1:0]       w_att_m1;

    // sweep counters
    logic [PW-1:0]                   r_p;
    logic [srl_pkg::PER_W-1:0]       r_ra;
    logic [PW-1:0]                   r_bba;
    logic [srl_pkg::PER_W-1:0]       r_rb;
    logic [PW-1:0]                   r_bbb;
    logic [AW-1:0]                   r_wm;
    logic [srl_pkg::WRAP_BITS-1:0]   r_wrap;
    logic                            w_p_lt_n;
    logic                            w_sweep_act;
    logic                            w_a_bit;
    logic                            w_b_bit;
    logic                            w_ra_wrap;
    logic                            w_rb_wrap;
    logic                            w_wm_wrap;

    // coincidence scan
    logic [NW-1:0]                   r_x;
    logic [AW-1:0]                   r_src;
    logic                            r_sv;
    logic [AW-1:0]                   r_sx;
    logic                            r_sabit;
    logic [NW-1:0]                   r_k;
    logic [AW-1:0]                   w_src0;
    logic                            w_src_wrap;
    logic                            w_wrap_bit;
    logic                            w_x_issue;
    logic                            w_scan_end;
    logic                            w_hit;

    // slot maps
    logic                            r_mem_b [N_MAX];
    logic                            r_mem_c [N_MAX];
    logic                            r_rd_b;
    logic                            r_rd_c;
    logic                            w_b_we;
    logic                            w_c_we;

    // division, base and seek
    logic [srl_pkg::ATT_W-1:0]       r_q;
    logic [NW-1:0]                   r_r;
    logic [srl_pkg::LAT_W-1:0]       r_base;
    logic [srl_pkg::ATT_W+NW-1:0]    w_prod;
    logic [NW-1:0]                   r_d;
    logic [AW-1:0]                   r_ya;
    logic                            r_dv;
    logic [NW-1:0]                   r_dd;
    logic [NW-1:0]                   r_hc;
    logic                            w_d_issue;
    logic                            w_ya_wrap;
    logic                            w_found;

    // result staging and output register
    logic [srl_pkg::LAT_W-1:0]       r_lat;
    logic                            r_nov;
    logic                            r_ov;
    srl_pkg::t_out                   r_out;
    logic                            w_out_free;

    srl_cfg #(
        .PERIOD_MAX (PERIOD_MAX),
        .MASK_BITS  (MASK_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    srl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_div_go),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_res      (w_div)
    );

    assign o_cfg_ready = 1'b1;
    assign w_n         = NW'(w_cfg.n);

    // ---------------------------------------------------------------------
    // Per-slot logic shared by sweep and scan
    // ---------------------------------------------------------------------
    assign w_att_m1   = (r_att == '0) ? '0 : r_att - srl_pkg::ATT_W'(1);
    assign w_a_bit    = slot_on(w_cfg.mask_a, r_ra, w_cfg.lim_a);
    assign w_ra_wrap  = (r_ra == w_cfg.per_a - srl_pkg::PER_W'(1));
    assign w_rb_wrap  = (r_rb == w_cfg.per_b - srl_pkg::PER_W'(1));
    assign w_wm_wrap  = (NW'(r_wm) == w_n - NW'(1));

    // Sweep: slots below n build map B; schedule A copies whose block starts
    // at or before n spill past n and fold back into the wrap vector.
    assign w_p_lt_n    = (r_p < PW'(w_n));
    assign w_sweep_act = w_p_lt_n || (r_bba <= PW'(w_n));
    // B is laid only over whole periods that fit inside n
    assign w_b_bit     = ((r_bbb + PW'(w_cfg.per_b)) <= PW'(w_n))
                         && slot_on(w_cfg.mask_b, r_rb, w_cfg.lim_b);
    assign w_b_we      = (r_state == srl_pkg::S_SWEEP) && w_p_lt_n;

    // Scan: slot x of A against slot (x - offset) mod n of B
    assign w_src0      = (r_offm == '0) ? '0 : AW'(w_n - NW'(r_offm));
    assign w_src_wrap  = (NW'(r_src) == w_n - NW'(1));
    assign w_wrap_bit  = (32'(r_x) < srl_pkg::WRAP_BITS) && r_wrap[WIX'(r_x)];
    assign w_x_issue   = (r_x < w_n);
    assign w_scan_end  = (r_x == w_n) && !r_sv;
    assign w_hit       = r_sabit && r_rd_b;
    assign w_c_we      = (r_state == srl_pkg::S_SCAN) && r_sv;

    // Seek: walk forward from the start slot, stop at hit number r_r (from zero)
    assign w_prod      = r_q * w_n;
    assign w_d_issue   = (r_d < w_n);
    assign w_ya_wrap   = (NW'(r_ya) == w_n - NW'(1));
    assign w_found     = (r_state == srl_pkg::S_SEEK) && r_dv && r_rd_c && (r_hc == r_r);

    assign w_out_free  = !r_ov || i_out_ready;

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srl_pkg::S_IDLE:      if (i_in_valid) n_state = srl_pkg::S_MOD_START;
            srl_pkg::S_MOD_START: if (w_div.done) n_state = srl_pkg::S_MOD_OFF;
            srl_pkg::S_MOD_OFF:   if (w_div.done) n_state = srl_pkg::S_SWEEP;
            srl_pkg::S_SWEEP:     if (!w_sweep_act) n_state = srl_pkg::S_SCAN;
            srl_pkg::S_SCAN: begin
                if (w_scan_end) begin
                    n_state = (r_k == '0) ? srl_pkg::S_DONE : srl_pkg::S_DIV_ATT;
                end
            end
            srl_pkg::S_DIV_ATT:   if (w_div.done) n_state = srl_pkg::S_MUL;
            srl_pkg::S_MUL:       n_state = srl_pkg::S_SEEK;
            srl_pkg::S_SEEK:      if (w_found) n_state = srl_pkg::S_DONE;
            srl_pkg::S_DONE:      if (w_out_free) n_state = srl_pkg::S_IDLE;
            default:              n_state = srl_pkg::S_IDLE;
        endcase
    end

    // divider requests: start mod n, offset mod n, (attempts-1) / k
    always_comb begin
        o_in_ready = 1'b0;
        w_div_go   = 1'b0;
        w_div_dvd  = '0;
        w_div_dvs  = srl_pkg::DIV_VW'(w_n);
        w_load_out = 1'b0;
        unique case (r_state)
            srl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                w_div_go   = i_in_valid;
                w_div_dvd  = srl_pkg::DIV_DW'(i_in_data.start_slot);
            end
            srl_pkg::S_MOD_START: begin
                w_div_go  = w_div.done;
                w_div_dvd = srl_pkg::DIV_DW'(r_off);
            end
            srl_pkg::S_SCAN: begin
                w_div_go  = w_scan_end && (r_k != '0);
                w_div_dvd = srl_pkg::DIV_DW'(w_att_m1);
                w_div_dvs = srl_pkg::DIV_VW'(r_k);
            end
            srl_pkg::S_DONE: begin
                w_load_out = w_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srl_pkg::S_IDLE;
            r_sv    <= 1'b0;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sv    <= (r_state == srl_pkg::S_SCAN) && w_x_issue;
            r_dv    <= (r_state == srl_pkg::S_SEEK) && w_d_issue;
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            srl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    r_off <= i_in_data.phase_offset;
                    r_att <= i_in_data.attempts;
                end
            end
            srl_pkg::S_MOD_START: begin
                if (w_div.done) r_startm <= AW'(w_div.rem);
            end
            srl_pkg::S_MOD_OFF: begin
                // arm the sweep
                if (w_div.done) begin
                    r_offm <= AW'(w_div.rem);
                    r_p    <= '0;
                    r_ra   <= '0;
                    r_bba  <= '0;
                    r_rb   <= '0;
                    r_bbb  <= '0;
                    r_wm   <= '0;
                end
            end
            srl_pkg::S_SWEEP: begin
                if (w_sweep_act) begin
                    // clear the wrap vector below n, then fold the overhang into it
                    if (w_p_lt_n) begin
                        r_wrap[WIX'(r_wm)] <= 1'b0;
                    end else if (w_a_bit) begin
                        r_wrap[WIX'(r_wm)] <= 1'b1;
                    end
                    r_p  <= r_p + PW'(1);
                    r_ra <= w_ra_wrap ? '0 : r_ra + srl_pkg::PER_W'(1);
                    if (w_ra_wrap) r_bba <= r_bba + PW'(w_cfg.per_a);
                    r_rb <= w_rb_wrap ? '0 : r_rb + srl_pkg::PER_W'(1);
                    if (w_rb_wrap) r_bbb <= r_bbb + PW'(w_cfg.per_b);
                    r_wm <= w_wm_wrap ? '0 : r_wm + AW'(1);
                end else begin
                    // arm the scan
                    r_x   <= '0;
                    r_ra  <= '0;
                    r_k   <= '0;
                    r_src <= w_src0;
                end
            end
            srl_pkg::S_SCAN: begin
                if (w_x_issue) begin
                    r_sx    <= AW'(r_x);
                    r_sabit <= w_a_bit || w_wrap_bit;
                    r_x     <= r_x + NW'(1);
                    r_ra    <= w_ra_wrap ? '0 : r_ra + srl_pkg::PER_W'(1);
                    r_src   <= w_src_wrap ? '0 : r_src + AW'(1);
                end
                if (r_sv && w_hit) r_k <= r_k + NW'(1);
                // empty result; overwritten by the seek when there are hits
                if (w_scan_end) begin
                    r_lat <= '0;
                    r_nov <= 1'b1;
                end
            end
            srl_pkg::S_DIV_ATT: begin
                if (w_div.done) begin
                    r_q <= w_div.quot;
                    r_r <= NW'(w_div.rem);
                end
            end
            srl_pkg::S_MUL: begin
                // whole rounds count n slots each
                r_base <= srl_pkg::LAT_W'(w_prod);
                r_d    <= '0;
                r_ya   <= r_startm;
                r_hc   <= '0;
            end
            srl_pkg::S_SEEK: begin
                if (w_d_issue) begin
                    r_dd <= r_d;
                    r_d  <= r_d + NW'(1);
                    r_ya <= w_ya_wrap ? '0 : r_ya + AW'(1);
                end
                if (r_dv && r_rd_c && !w_found) r_hc <= r_hc + NW'(1);
                if (w_found) begin
                    r_lat <= r_base + srl_pkg::LAT_W'(r_dd);
                    r_nov <= 1'b0;
                end
            end
            srl_pkg::S_DONE: begin
                if (w_out_free) r_out <= '{latency: r_lat, no_overlap: r_nov};
            end
            default: ;
        endcase
    end

    // map B: written in slot order by the sweep, read at the rotated slot by the scan
    always_ff @(posedge i_clk) begin
        if (w_b_we) r_mem_b[r_p[AW-1:0]] <= w_b_bit;
        r_rd_b <= r_mem_b[r_src];
    end

    // coincidence map: written by the scan, read from the start slot by the seek
    always_ff @(posedge i_clk) begin
        if (w_c_we) r_mem_c[r_sx] <= w_hit;
        r_rd_c <= r_mem_c[r_ya];
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `SRL_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `SRL_ASSERT_IMP(a_hits_bounded, i_clk, i_rst_n, r_state == srl_pkg::S_SCAN, r_k <= r_x)
    `SRL_ASSERT_IMP(a_seek_count, i_clk, i_rst_n, r_state == srl_pkg::S_SEEK, r_hc <= r_r)
    `SRL_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, r_ov && r_out.no_overlap, r_out.latency == '0)

endmodule

@@ design/srl_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on srl_pkg for widths and the result struct.
module srl_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [srl_pkg::DIV_DW-1:0]   i_dividend,
    input  logic [srl_pkg::DIV_VW-1:0]   i_divisor,
    output srl_pkg::t_div_res            o_res
);
    localparam int CW = $clog2(srl_pkg::DIV_DW + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [srl_pkg::DIV_VW-1:0]  r_rem;
    logic [srl_pkg::DIV_DW-1:0]  r_quot;
    logic [srl_pkg::DIV_VW-1:0]  r_dvs;
    logic [srl_pkg::DIV_VW:0]    w_shift;
    logic [srl_pkg::DIV_VW:0]    w_diff;
    logic                        w_ge;

    assign w_shift = {r_rem, r_quot[srl_pkg::DIV_DW-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(srl_pkg::DIV_DW);
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                // keep the partial remainder below the divisor
                r_rem  <= w_ge ? w_diff[srl_pkg::DIV_VW-1:0] : w_shift[srl_pkg::DIV_VW-1:0];
                r_quot <= {r_quot[srl_pkg::DIV_DW-2:0], w_ge};
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res = '{done: r_done, quot: r_quot, rem: r_rem};

endmodule

@@ design/srl_cfg.sv @@
// Configuration register file with effective-value normalization.
// Depends on srl_pkg for the register index codes and the t_cfg struct.
module srl_cfg #(
    parameter int PERIOD_MAX = 4096,
    parameter int MASK_BITS  = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [srl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srl_pkg::MASK_W-1:0]      i_cfg_data,
    output srl_pkg::t_cfg                   o_cfg
);
    logic [srl_pkg::MASK_W-1:0] r_mask_a;
    logic [srl_pkg::PER_W-1:0]  r_per_a;
    logic [srl_pkg::MASK_W-1:0] r_mask_b;
    logic [srl_pkg::PER_W-1:0]  r_per_b;
    logic [srl_pkg::CP_W-1:0]   r_cp;
    logic [srl_pkg::PER_W-1:0]  w_pa;
    logic [srl_pkg::PER_W-1:0]  w_pb;
    logic [srl_pkg::CP_W-1:0]   w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_a <= srl_pkg::MASK_W'(1);
            r_per_a  <= srl_pkg::PER_W'(1);
            r_mask_b <= srl_pkg::MASK_W'(1);
            r_per_b  <= srl_pkg::PER_W'(1);
            r_cp     <= srl_pkg::CP_W'(1);
        end else if (i_cfg_valid) begin
            unique case (srl_pkg::t_cfg_reg'(i_cfg_index))
                srl_pkg::REG_A_MASK:   r_mask_a <= i_cfg_data;
                srl_pkg::REG_A_PERIOD: r_per_a  <= i_cfg_data[srl_pkg::PER_W-1:0];
                srl_pkg::REG_B_MASK:   r_mask_b <= i_cfg_data;
                srl_pkg::REG_B_PERIOD: r_per_b  <= i_cfg_data[srl_pkg::PER_W-1:0];
                srl_pkg::REG_COMMON:   r_cp     <= i_cfg_data[srl_pkg::CP_W-1:0];
                default: ;
            endcase
        end
    end

    // zero period acts as one; common period clamps into 1..PERIOD_MAX
    always_comb begin
        w_pa = (r_per_a == '0) ? srl_pkg::PER_W'(1) : r_per_a;
        w_pb = (r_per_b == '0) ? srl_pkg::PER_W'(1) : r_per_b;
        if (r_cp == '0) begin
            w_n = srl_pkg::CP_W'(1);
        end else if (32'(r_cp) > PERIOD_MAX) begin
            w_n = srl_pkg::CP_W'(PERIOD_MAX);
        end else begin
            w_n = r_cp;
        end
    end

    assign o_cfg = '{
        mask_a: r_mask_a,
        per_a:  w_pa,
        lim_a:  (32'(w_pa) < MASK_BITS) ? w_pa : srl_pkg::PER_W'(MASK_BITS),
        mask_b: r_mask_b,
        per_b:  w_pb,
        lim_b:  (32'(w_pb) < MASK_BITS) ? w_pb : srl_pkg::PER_W'(MASK_BITS),
        n:      w_n
    };

endmodule

@@ dv/tb.sv @@
// Self-checking bench for schedule_rendezvous_latency: directed and random words
// against an in-bench latency predictor. Depends on srl_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import srl_pkg::*;

    localparam int PERIOD_MAX = 4096;
    localparam int MASK_BITS  = 64;
    // Index outside the register map; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 60000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [MASK_W-1:0]    i_cfg_data;

    // Bench copy of the schedule registers, reset values as the block has them.
    logic [MASK_W-1:0] sched_a_mask = 64'd1;
    logic [PER_W-1:0]  sched_a_per  = 7'd1;
    logic [MASK_W-1:0] sched_b_mask = 64'd1;
    logic [PER_W-1:0]  sched_b_per  = 7'd1;
    logic [CP_W-1:0]   common_len   = 13'd1;

    t_in  words_pending[$];   // words waiting to go out on the input channel
    t_out latency_due[$];     // predicted results, oldest first

    // Handshake flags, set at the rising edge and read by the driver at the falling one.
    bit          in_fire;
    bit          out_fire;
    bit          in_burst;
    bit          out_burst;
    int unsigned in_gap;
    int unsigned out_gap;
    int unsigned stall_cycles;
    int unsigned mismatches;

    schedule_rendezvous_latency #(
        .PERIOD_MAX(PERIOD_MAX),
        .MASK_BITS (MASK_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Lay one schedule over n slots: rep copies spaced by the period, wrapped
    // modulo n, using only the mask bits below min(period, mask width).
    function automatic bit [PERIOD_MAX-1:0] expand_schedule(logic [MASK_W-1:0] mask,
                                                           int unsigned per,
                                                           int unsigned reps,
                                                           int unsigned n);
        bit [PERIOD_MAX-1:0] awake;
        int unsigned lim;
        awake = '0;
        lim = (per < MASK_BITS) ? per : MASK_BITS;
        for (int unsigned rep = 0; rep < reps; rep++) begin
            for (int unsigned s = 0; s < lim; s++) begin
                if (mask[s]) awake[(s + rep * per) % n] = 1'b1;
            end
        end
        return awake;
    endfunction

    // Predict the result word for one input word under the current registers.
    function automatic t_out rendezvous_latency(t_in w);
        int unsigned n, pa, pb, start, off, att, k, idx, rem, pos, nx;
        longint unsigned t;
        bit [PERIOD_MAX-1:0] awake_a, awake_b;
        int unsigned hits[$];
        t_out r;
        // Clamp the common period, treat zero periods and zero attempts as one.
        n = common_len;
        if (n == 0) n = 1;
        if (n > PERIOD_MAX) n = PERIOD_MAX;
        pa = (sched_a_per == 0) ? 1 : sched_a_per;
        pb = (sched_b_per == 0) ? 1 : sched_b_per;
        start = w.start_slot % n;
        off   = w.phase_offset % n;
        att   = (w.attempts == 0) ? 1 : w.attempts;
        // Schedule A gets one extra copy that wraps onto the front; B does not.
        awake_a = expand_schedule(sched_a_mask, pa, n / pa + 1, n);
        awake_b = expand_schedule(sched_b_mask, pb, n / pb, n);
        for (int unsigned x = 0; x < n; x++) begin
            if (awake_a[x] && awake_b[(x + n - off) % n]) hits.push_back(x);
        end
        k = hits.size();
        r = '0;
        if (k == 0) begin
            r.no_overlap = 1'b1;
            return r;
        end
        // First coincidence at or after start, else wrap to the first one.
        idx = 0;
        for (int unsigned j = 0; j < k; j++) begin
            if (hits[j] >= start) begin
                idx = j;
                break;
            end
        end
        if (hits[idx] >= start) t = hits[idx] - start;
        else t = n - (start - hits[idx]);
        // Whole rounds cost n slots each; walk the remainder hit by hit.
        att = att - 1;
        t += longint'(att / k) * n;
        rem = att % k;
        pos = idx;
        while (rem > 0) begin
            nx = (pos + 1) % k;
            if (nx > pos) t += hits[nx] - hits[pos];
            else t += n - (hits[pos] - hits[nx]);
            pos = nx;
            rem--;
        end
        r.latency = t[LAT_W-1:0];
        return r;
    endfunction

    // Driver: launch words from the pending queue and pace the result side.
    // Each side waits out a randomly drawn gap between words, and now and then switches
    // into a burst mode with no idling at all.
    always @(negedge i_clk) begin
        bit valid_next;
        if (i_rst_n) begin
            valid_next = i_in_valid && !in_fire;
            if (!valid_next) begin
                if (in_gap != 0) begin
                    in_gap--;
                end else if (words_pending.size() != 0) begin
                    i_in_data <= words_pending.pop_front();
                    valid_next = 1'b1;
                    if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
                    in_gap = in_burst ? 0 : $urandom_range(0, 16);
                end
            end
            i_in_valid <= valid_next;

            if (out_fire) begin
                if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
                out_gap = out_burst ? 0 : $urandom_range(0, 16);
            end else if (out_gap != 0) begin
                out_gap--;
            end
            i_out_ready <= (out_gap == 0);
        end
    end

    // Monitor: track register writes, predict on every accepted input word,
    // check every accepted result word against the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        bit   moved;
        if (!i_rst_n) begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end else begin
            in_fire  <= i_in_valid && o_in_ready;
            out_fire <= o_out_valid && i_out_ready;
            moved = (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready);

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_A_MASK:   sched_a_mask = i_cfg_data;
                    REG_A_PERIOD: sched_a_per  = i_cfg_data[PER_W-1:0];
                    REG_B_MASK:   sched_b_mask = i_cfg_data;
                    REG_B_PERIOD: sched_b_per  = i_cfg_data[PER_W-1:0];
                    REG_COMMON:   common_len   = i_cfg_data[CP_W-1:0];
                    default: ;
                endcase
            end

            // Check before pushing so a word taken at this edge never meets
            // the result of its predecessor.
            if (o_out_valid && i_out_ready) begin
                if (latency_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result latency %0d no_overlap %0d",
                             $time, o_out_data.latency, o_out_data.no_overlap);
                end else begin
                    want = latency_due.pop_front();
                    if (o_out_data.latency !== want.latency) begin
                        mismatches++;
                        $display("%0t: latency expected %0d got %0d",
                                 $time, want.latency, o_out_data.latency);
                    end
                    if (o_out_data.no_overlap !== want.no_overlap) begin
                        mismatches++;
                        $display("%0t: no_overlap expected %0d got %0d",
                                 $time, want.no_overlap, o_out_data.no_overlap);
                    end
                end
            end

            if (i_in_valid && o_in_ready) latency_due.push_back(rendezvous_latency(i_in_data));

            // Watchdog: count cycles in which no channel moves a word.
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("[schedule_rendezvous_latency] ERROR");
                $finish;
            end
        end
    end

    // Block until no word is queued, on the bus, or owed by the block.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (words_pending.size() != 0 || i_in_valid || latency_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain the block, then write all five schedule registers.
    task automatic configure(input logic [MASK_W-1:0] a_mask, input logic [MASK_W-1:0] a_per,
                             input logic [MASK_W-1:0] b_mask, input logic [MASK_W-1:0] b_per,
                             input logic [MASK_W-1:0] cp);
        wait_idle();
        write_reg(REG_A_MASK, a_mask);
        write_reg(REG_A_PERIOD, a_per);
        write_reg(REG_B_MASK, b_mask);
        write_reg(REG_B_PERIOD, b_per);
        write_reg(REG_COMMON, cp);
    endtask

    task automatic queue_word(input int unsigned start, input int unsigned off,
                              input int unsigned att);
        t_in w;
        w.start_slot   = start[SLOT_W-1:0];
        w.phase_offset = off[SLOT_W-1:0];
        w.attempts     = att[ATT_W-1:0];
        words_pending.push_back(w);
    endtask

    // Dense, medium or sparse random mask; sparse ones make empty overlaps likely.
    function automatic logic [MASK_W-1:0] random_mask();
        logic [MASK_W-1:0] m;
        m = {$urandom, $urandom};
        case ($urandom_range(0, 2))
            0: ;
            1: m = m & {$urandom, $urandom};
            default: m = m & {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        endcase
        return m;
    endfunction

    initial begin
        int unsigned pa, pb, g, h, rmd, span, att, quiet;
        logic [MASK_W-1:0] junk_a, junk_b;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: one slot, always coincident. Cover field extremes
        // and attempts of zero.
        queue_word(0, 0, 1);
        queue_word(4095, 4095, 65535);
        queue_word(17, 3, 0);

        // Full A against the first and last mask bit of B over two B copies;
        // starts past the last hit wrap into the next round.
        configure(64'hFFFF_FFFF_FFFF_FFFF, 64'd64, 64'h8000_0000_0000_0001, 64'd64, 64'd128);
        queue_word(0, 0, 1);
        queue_word(100, 0, 1);
        queue_word(127, 1, 2);
        queue_word(4095, 4095, 65535);
        queue_word(200, 127, 0);
        queue_word(64, 64, 3);

        // Interleaved schedules: no overlap at even offsets, overlap at odd.
        configure(64'h5, 64'd4, 64'hA, 64'd4, 64'd16);
        queue_word(0, 0, 1);
        queue_word(5, 1, 65535);
        queue_word(15, 2, 7);

        // Zero period for A, period above mask width for B, common period
        // saturated; garbage in the upper data bits must be dropped.
        configure(random_mask(), 64'hFFFF_FFFF_FFFF_FF80, random_mask(),
                  64'hAAAA_AAAA_AAAA_AAFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_word($urandom_range(0, 4095), $urandom_range(0, 4095), 65535);
        queue_word(4095, 0, 1);

        // Zero common period, plus a write to an unused index that must be ignored.
        configure(64'hFFFF_FFFF_FFFF_FFFF, 64'd3, 64'h6, 64'd5, 64'h0);
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(4095, 4095, 9);
        queue_word(0, 0, 0);

        // Longest schedules over the largest common period, most attempts.
        configure(64'h1, 64'd127, 64'h1, 64'd127, 64'd4096);
        queue_word(4095, 0, 65535);
        queue_word(0, 4095, 1);

        // Random phases. Most use periods whose common multiple fits in 1024
        // slots; every fourth is noise with any period and a common period of 0..700.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 4 == 3) begin
                pa = $urandom_range(0, 127);
                pb = $urandom_range(0, 127);
                span = $urandom_range(0, 700);
            end else begin
                pa = $urandom_range(1, 64);
                pb = $urandom_range(1, 64);
                g = pa;
                h = pb;
                while (h != 0) begin
                    rmd = g % h;
                    g = h;
                    h = rmd;
                end
                span = pa / g * pb;
                if (span > 1024) begin
                    pb = pa;
                    span = pa;
                end
                span = span * $urandom_range(1, 1024 / span);
            end
            junk_a = {$urandom, $urandom};
            junk_b = {$urandom, $urandom};
            configure(random_mask(), {junk_a[63:PER_W], pa[PER_W-1:0]},
                      random_mask(), {junk_b[63:PER_W], pb[PER_W-1:0]},
                      {junk_a[63:CP_W], span[CP_W-1:0]});
            repeat (12) begin
                case ($urandom_range(0, 3))
                    0: att = $urandom_range(1, 4);
                    1: att = $urandom_range(1, 64);
                    2: att = $urandom_range(0, 65535);
                    default: att = $urandom_range(1, 1024);
                endcase
                queue_word($urandom_range(0, 4095), $urandom_range(0, 4095), att);
            end
        end

        // Drain, then give the block one more word time to show anything stray.
        wait_idle();
        quiet = (common_len == 0) ? 1 : ((common_len > PERIOD_MAX) ? PERIOD_MAX : common_len);
        quiet = 3 * quiet + 200;
        repeat (quiet) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("[schedule_rendezvous_latency] OK");
        end else begin
            $display("[schedule_rendezvous_latency] ERROR");
        end
        $finish;
    end

endmodule
